// ===== rtl/core/wsd_pkg.sv =====
// Package for the WebSocket frame deframer: parse phases, frame actions,
// opcode codes, the parser state and result records, and the opcode classifier.
// No dependencies.
package wsd_pkg;

  // Parse phase of the receive stream.
  typedef enum logic [2:0] {
    PhHdr0  = 3'd0,
    PhHdr1  = 3'd1,
    PhExtHi = 3'd2,
    PhExtLo = 3'd3,
    PhMask  = 3'd4,
    PhPay   = 3'd5
  } phase_e;

  // What the current frame is used for once its header is complete.
  typedef enum logic [2:0] {
    ActNone  = 3'd0,
    ActText  = 3'd1,
    ActPing  = 3'd2,
    ActClose = 3'd3,
    ActSkip  = 3'd4
  } action_e;

  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;

  localparam logic [6:0]  StdLenMax = 7'd125;
  localparam logic [15:0] KeyBytes  = 16'd4;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] count;
    logic [15:0] length;
    logic [31:0] mask_key;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic        bad_seen;
    logic [15:0] reason;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_payload;
    logic [3:0]  frame_opcode;
    logic        final_flag;
    logic        was_masked;
    action_e     frame_action;
    logic        not_ascii;
    logic        frame_end;
    logic        text_accepted;
    logic [15:0] payload_length;
    logic [15:0] close_reason;
  } result_t;

  function automatic action_e classify(input logic [3:0] opcode);
    action_e act;
    priority if (opcode == OpClose) act = ActClose;
    else if (opcode == OpPing) act = ActPing;
    else if (opcode == OpText) act = ActText;
    else act = ActSkip;
    return act;
  endfunction

endpackage

// ===== rtl/core/wsd_step.sv =====
// Combinational parse step: takes the current parser state and one received
// byte and produces the next state and the result record.
// Depends on wsd_pkg.
module wsd_step (
  input  wsd_pkg::parse_state_t st_q_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  restart_i,
  output wsd_pkg::parse_state_t st_d_o,
  output wsd_pkg::result_t      res_o
);

  wsd_pkg::parse_state_t st_d;
  wsd_pkg::phase_e       phase;
  wsd_pkg::action_e      action;
  logic                  hdr_done;
  logic                  classified;
  logic                  end_f;
  logic                  pay;
  logic                  bad_now;
  logic [7:0]            key_byte;
  logic [7:0]            ob;
  logic [16:0]           cnt_inc;

  always_comb begin
    st_d       = st_q_i;
    phase      = restart_i ? wsd_pkg::PhHdr0 : st_q_i.phase;
    st_d.phase = phase;
    hdr_done   = 1'b0;
    classified = 1'b0;
    end_f      = 1'b0;
    pay        = 1'b0;
    bad_now    = 1'b0;
    ob         = 8'h00;
    cnt_inc    = {1'b0, st_q_i.count} + 17'd1;

    unique case (st_q_i.count[1:0])
      2'd0: key_byte = st_q_i.mask_key[31:24];
      2'd1: key_byte = st_q_i.mask_key[23:16];
      2'd2: key_byte = st_q_i.mask_key[15:8];
      default: key_byte = st_q_i.mask_key[7:0];
    endcase

    unique case (phase)
      wsd_pkg::PhHdr1: begin
        st_d.masked = in_byte_i[7];
        if (in_byte_i[6:0] <= wsd_pkg::StdLenMax) begin
          st_d.length = {9'd0, in_byte_i[6:0]};
          hdr_done    = 1'b1;
        end else begin
          // Both extended length codes read a 16-bit length.
          st_d.length = 16'd0;
          st_d.phase  = wsd_pkg::PhExtHi;
        end
      end
      wsd_pkg::PhExtHi: begin
        st_d.length = {in_byte_i, 8'h00};
        st_d.phase  = wsd_pkg::PhExtLo;
      end
      wsd_pkg::PhExtLo: begin
        st_d.length = {st_q_i.length[15:8], in_byte_i};
        hdr_done    = 1'b1;
      end
      wsd_pkg::PhMask: begin
        st_d.mask_key = {st_q_i.mask_key[23:0], in_byte_i};
        st_d.count    = cnt_inc[15:0];
        if (cnt_inc[15:0] >= wsd_pkg::KeyBytes) begin
          st_d.count = 16'd0;
          classified = 1'b1;
          if (st_q_i.length == 16'd0) begin
            end_f = 1'b1;
          end else begin
            st_d.phase = wsd_pkg::PhPay;
          end
        end
      end
      wsd_pkg::PhPay: begin
        ob         = in_byte_i ^ key_byte;
        pay        = 1'b1;
        classified = 1'b1;
        if (st_q_i.opcode == wsd_pkg::OpText && ob[7]) begin
          bad_now       = 1'b1;
          st_d.bad_seen = 1'b1;
        end
        if (st_q_i.opcode == wsd_pkg::OpClose) begin
          if (st_q_i.count == 16'd0) begin
            st_d.reason = {ob, 8'h00};
          end else if (st_q_i.count == 16'd1) begin
            st_d.reason = {st_q_i.reason[15:8], ob};
          end
        end
        st_d.count = cnt_inc[15:0];
        if (cnt_inc >= {1'b0, st_q_i.length}) begin
          end_f = 1'b1;
        end
      end
      default: begin
        // First header byte; unused phase codes land here as well.
        st_d.fin      = in_byte_i[7];
        st_d.opcode   = in_byte_i[3:0];
        st_d.masked   = 1'b0;
        st_d.length   = 16'd0;
        st_d.mask_key = 32'd0;
        st_d.count    = 16'd0;
        st_d.bad_seen = 1'b0;
        st_d.reason   = 16'd0;
        st_d.phase    = wsd_pkg::PhHdr1;
      end
    endcase

    if (hdr_done) begin
      st_d.count = 16'd0;
      if (st_d.masked) begin
        st_d.phase = wsd_pkg::PhMask;
      end else begin
        classified = 1'b1;
        if (st_d.length == 16'd0) begin
          end_f = 1'b1;
        end else begin
          st_d.phase = wsd_pkg::PhPay;
        end
      end
    end

    action = classified ? wsd_pkg::classify(st_d.opcode) : wsd_pkg::ActNone;

    res_o.out_byte       = ob;
    res_o.is_payload     = pay;
    res_o.frame_opcode   = st_d.opcode;
    res_o.final_flag     = st_d.fin;
    res_o.was_masked     = st_d.masked;
    res_o.frame_action   = action;
    res_o.not_ascii      = bad_now;
    res_o.frame_end      = end_f;
    res_o.text_accepted  = end_f && action == wsd_pkg::ActText &&
                           st_d.length != 16'd0 && !st_d.bad_seen;
    res_o.payload_length = st_d.length;
    // The reason code is shown once both of its bytes are in, before a frame
    // end returns the parser to the first header byte.
    res_o.close_reason   = (action == wsd_pkg::ActClose && st_d.length >= 16'd2 &&
                            st_d.count >= 16'd2 && st_d.phase == wsd_pkg::PhPay) ?
                           st_d.reason : 16'd0;

    if (end_f) begin
      st_d.phase = wsd_pkg::PhHdr0;
    end
    st_d_o = st_d;
  end

endmodule

// ===== rtl/core/websocket_frame_deframer_core.sv =====
// Top level of the WebSocket frame deframer: parser state registers, the
// parse step and the result register. Depends on wsd_pkg and wsd_step.
//
// The deframer takes one received byte per transaction and returns exactly
// one result per byte. It parses the two header bytes, an optional 16-bit
// extended length (length codes 126 and 127 both read 16 bits), an optional
// 4-byte mask key, and unmasks payload bytes. Throughput is one byte per
// clock cycle: the whole parse step is a single pass of logic from the state
// registers to the result register, and a byte is taken in any cycle in which
// the result register is empty or its result is taken in that same cycle.
// Each accepted byte's result is registered for the next cycle. restart_i drops
// any partial frame and treats the byte as the first header byte.
module websocket_frame_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        is_payload_o,
  output logic [3:0]  frame_opcode_o,
  output logic        final_flag_o,
  output logic        was_masked_o,
  output logic [2:0]  frame_action_o,
  output logic        not_ascii_o,
  output logic        frame_end_o,
  output logic        text_accepted_o,
  output logic [15:0] payload_length_o,
  output logic [15:0] close_reason_o
);

  wsd_pkg::parse_state_t st_q, st_d;
  wsd_pkg::result_t      res_d, res_q;
  logic                  out_valid_q;
  logic                  accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  wsd_step u_step (
    .st_q_i    (st_q),
    .in_byte_i (in_byte_i),
    .restart_i (restart_i),
    .st_d_o    (st_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase    <= wsd_pkg::PhHdr0;
      st_q.count    <= 16'd0;
      st_q.length   <= 16'd0;
      st_q.mask_key <= 32'd0;
      st_q.fin      <= 1'b0;
      st_q.opcode   <= 4'd0;
      st_q.masked   <= 1'b0;
      st_q.bad_seen <= 1'b0;
      st_q.reason   <= 16'd0;
      res_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        st_q        <= st_d;
        res_q       <= res_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = res_q.out_byte;
  assign is_payload_o     = res_q.is_payload;
  assign frame_opcode_o   = res_q.frame_opcode;
  assign final_flag_o     = res_q.final_flag;
  assign was_masked_o     = res_q.was_masked;
  assign frame_action_o   = res_q.frame_action;
  assign not_ascii_o      = res_q.not_ascii;
  assign frame_end_o      = res_q.frame_end;
  assign text_accepted_o  = res_q.text_accepted;
  assign payload_length_o = res_q.payload_length;
  assign close_reason_o   = res_q.close_reason;

endmodule
